// File: rtl/cpm_pkg.sv
// ----------------------------------------------------------------------------
// cpm_pkg
// Shared widths, register codes, colormap tables and stage types for the
// clamped piecewise-linear colormap.
// ----------------------------------------------------------------------------
package cpm_pkg;

   // Register file
   localparam int CLAMP_W     = 15;
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLAMP_MAX = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLAMP_MIN = 2'd1;
   localparam logic [CLAMP_W-1:0] CLAMP_MAX_RESET = 15'd400;
   localparam logic [CLAMP_W-1:0] CLAMP_MIN_RESET = 15'd0;

   // Normalizing divider
   localparam int QUO_W      = 16;
   localparam int T_W        = 17;
   localparam logic [T_W-1:0] T_FULL = 17'd65536;
   localparam int DIV_STEPS  = 4;                  // quotient bits per stage
   localparam int DIV_STAGES = QUO_W / DIV_STEPS;

   // Colormap
   localparam int NUM_SEGS    = 5;
   localparam int SEG_IDX_W   = 3;
   localparam int SPAN_W      = 15;
   localparam int NUM_W       = 23;
   localparam int DELTA_W     = 9;
   localparam int RECIP_W     = 19;
   localparam int RECIP_SHIFT = 32;
   localparam int CHAN_W      = 8;
   localparam int NUM_CHANS   = 3;
   localparam int CH_RED      = 0;
   localparam int CH_GREEN    = 1;
   localparam int CH_BLUE     = 2;

   localparam logic [T_W-1:0] SEG_BND [NUM_SEGS+1] = '{
      17'd0, 17'd21845, 17'd30802, 17'd42271, 17'd51839, 17'd65536
   };

   localparam logic [SPAN_W-1:0] SEG_SPAN [NUM_SEGS] = '{
      15'd21845, 15'd8957, 15'd11469, 15'd9568, 15'd13697
   };

   // start * span per segment and channel
   localparam logic [NUM_W-1:0] SEG_BASE [NUM_SEGS][NUM_CHANS] = '{
      '{23'(22 * 21845),  23'(30 * 21845),  23'(151 * 21845)},
      '{23'(0),           23'(181 * 8957),  23'(226 * 8957)},
      '{23'(76 * 11469),  23'(140 * 11469), 23'(43 * 11469)},
      '{23'(0),           23'(206 * 9568),  23'(24 * 9568)},
      '{23'(254 * 13697), 23'(209 * 13697), 23'(65 * 13697)}
   };

   // end - start per segment and channel
   localparam logic signed [DELTA_W-1:0] SEG_DELTA [NUM_SEGS][NUM_CHANS] = '{
      '{-9'sd22,  9'sd151,  9'sd75},
      '{ 9'sd76, -9'sd41,  -9'sd183},
      '{-9'sd76,  9'sd66,  -9'sd19},
      '{ 9'sd254, 9'sd3,    9'sd41},
      '{ 9'sd1,  -9'sd209, -9'sd65}
   };

   // floor(2^32 / span); estimate is low by at most one
   localparam longint unsigned RECIP_SCALE = 64'd1 << RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] SEG_RECIP [NUM_SEGS] = '{
      19'(RECIP_SCALE / 64'd21845),
      19'(RECIP_SCALE / 64'd8957),
      19'(RECIP_SCALE / 64'd11469),
      19'(RECIP_SCALE / 64'd9568),
      19'(RECIP_SCALE / 64'd13697)
   };

   typedef struct packed {
      logic               valid;
      logic               zero;   // clamp_max is zero
      logic               sat;    // clamped value at or above clamp_max
      logic [CLAMP_W-1:0] rem;
      logic [QUO_W-1:0]   quo;
   } div_stage_type;

   typedef struct packed {
      logic           valid;
      logic [T_W-1:0] t;
   } frac_type;

   typedef logic [NUM_CHANS-1:0][CHAN_W-1:0] rgb_type;

   typedef struct packed {
      logic    valid;
      rgb_type rgb;
   } color_type;

endpackage

// File: rtl/cpm_div.sv
// ----------------------------------------------------------------------------
// cpm_div
// Pipelined restoring divider: t = clamped * 65536 / clamp_max, four
// quotient bits per stage, with saturation and zero-divisor handling.
// ----------------------------------------------------------------------------
module cpm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  cpm_pkg::div_stage_type        start,
   output logic                          start_ready,
   input  logic [cpm_pkg::CLAMP_W-1:0]   divisor,
   output cpm_pkg::frac_type             frac,
   input  logic                          frac_ready
);

   cpm_pkg::div_stage_type stage_ff [cpm_pkg::DIV_STAGES];
   cpm_pkg::div_stage_type stage_in [cpm_pkg::DIV_STAGES];
   cpm_pkg::div_stage_type chain    [cpm_pkg::DIV_STAGES];
   logic [cpm_pkg::DIV_STAGES:0] stage_en;
   cpm_pkg::div_stage_type last;

   always_comb begin
      stage_en[cpm_pkg::DIV_STAGES] = frac_ready;
      for (int s = cpm_pkg::DIV_STAGES - 1; s >= 0; s--) begin
         stage_en[s] = !stage_ff[s].valid || stage_en[s+1];
      end
   end

   assign start_ready = stage_en[0];

   always_comb begin
      chain[0] = start;
      for (int s = 1; s < cpm_pkg::DIV_STAGES; s++) begin
         chain[s] = stage_ff[s-1];
      end
   end

   always_comb begin
      cpm_pkg::div_stage_type step;
      logic [cpm_pkg::CLAMP_W:0] shifted;
      logic fits;
      for (int s = 0; s < cpm_pkg::DIV_STAGES; s++) begin
         step = chain[s];
         for (int b = 0; b < cpm_pkg::DIV_STEPS; b++) begin
            shifted   = {step.rem, 1'b0};
            fits      = shifted >= {1'b0, divisor};
            step.rem  = fits ? cpm_pkg::CLAMP_W'(shifted - {1'b0, divisor})
                             : shifted[cpm_pkg::CLAMP_W-1:0];
            step.quo  = {step.quo[cpm_pkg::QUO_W-2:0], fits};
         end
         stage_in[s] = step;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < cpm_pkg::DIV_STAGES; s++) begin
         if (reset) begin
            stage_ff[s].valid <= 1'b0;
         end else if (stage_en[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign last = stage_ff[cpm_pkg::DIV_STAGES-1];

   always_comb begin
      frac.valid = last.valid;
      if (last.zero) begin
         frac.t = '0;
      end else if (last.sat) begin
         frac.t = cpm_pkg::T_FULL;
      end else begin
         frac.t = {1'b0, last.quo};
      end
   end

endmodule

// File: rtl/cpm_lerp.sv
// ----------------------------------------------------------------------------
// cpm_lerp
// Segment lookup and per-channel linear interpolation: segment select,
// numerator multiply, reciprocal multiply, remainder correction.
// ----------------------------------------------------------------------------
module cpm_lerp (
   input  logic                 clock,
   input  logic                 reset,
   input  cpm_pkg::frac_type    frac,
   output logic                 frac_ready,
   output cpm_pkg::color_type   color,
   input  logic                 color_ready
);

   localparam int PROD_W = cpm_pkg::SPAN_W + 1 + cpm_pkg::DELTA_W;
   localparam int WIDE_W = cpm_pkg::NUM_W + cpm_pkg::RECIP_W;

   logic seg_en, mul_en, rcp_en, out_en;
   logic seg_valid_ff, mul_valid_ff, rcp_valid_ff, out_valid_ff;

   logic [cpm_pkg::SEG_IDX_W-1:0] seg_k_ff, seg_k_in, mul_k_ff, rcp_k_ff;
   logic [cpm_pkg::SPAN_W-1:0]    seg_dt_ff, seg_dt_in;
   logic [cpm_pkg::NUM_W-1:0]     mul_num_ff [cpm_pkg::NUM_CHANS];
   logic [cpm_pkg::NUM_W-1:0]     mul_num_in [cpm_pkg::NUM_CHANS];
   logic [cpm_pkg::NUM_W-1:0]     rcp_num_ff [cpm_pkg::NUM_CHANS];
   logic [cpm_pkg::CHAN_W-1:0]    rcp_quo_ff [cpm_pkg::NUM_CHANS];
   logic [cpm_pkg::CHAN_W-1:0]    rcp_quo_in [cpm_pkg::NUM_CHANS];
   logic [cpm_pkg::NUM_W-1:0]     fix_rem    [cpm_pkg::NUM_CHANS];
   cpm_pkg::rgb_type              out_rgb_ff, out_rgb_in;

   assign out_en     = !out_valid_ff || color_ready;
   assign rcp_en     = !rcp_valid_ff || out_en;
   assign mul_en     = !mul_valid_ff || rcp_en;
   assign seg_en     = !seg_valid_ff || mul_en;
   assign frac_ready = seg_en;

   // Segment select: first segment is closed at zero, the rest open below
   always_comb begin
      seg_k_in = '0;
      for (int i = 1; i < cpm_pkg::NUM_SEGS; i++) begin
         if (frac.t > cpm_pkg::SEG_BND[i]) begin
            seg_k_in = cpm_pkg::SEG_IDX_W'(i);
         end
      end
      seg_dt_in = cpm_pkg::SPAN_W'(frac.t - cpm_pkg::SEG_BND[seg_k_in]);
   end

   // num = start * span + dt * (end - start); never negative inside a segment
   always_comb begin
      logic signed [PROD_W-1:0] prod;
      logic signed [PROD_W-1:0] sum;
      for (int c = 0; c < cpm_pkg::NUM_CHANS; c++) begin
         prod = $signed({1'b0, seg_dt_ff}) * cpm_pkg::SEG_DELTA[seg_k_ff][c];
         sum  = $signed(PROD_W'(cpm_pkg::SEG_BASE[seg_k_ff][c])) + prod;
         mul_num_in[c] = sum[cpm_pkg::NUM_W-1:0];
      end
   end

   always_comb begin
      logic [WIDE_W-1:0] wide;
      for (int c = 0; c < cpm_pkg::NUM_CHANS; c++) begin
         wide = WIDE_W'(mul_num_ff[c]) * WIDE_W'(cpm_pkg::SEG_RECIP[mul_k_ff]);
         rcp_quo_in[c] = wide[cpm_pkg::RECIP_SHIFT +: cpm_pkg::CHAN_W];
      end
   end

   // Estimate may be one short; fix from the remainder
   always_comb begin
      logic [cpm_pkg::NUM_W-1:0] back;
      logic [cpm_pkg::NUM_W-1:0] span;
      span = cpm_pkg::NUM_W'(cpm_pkg::SEG_SPAN[rcp_k_ff]);
      for (int c = 0; c < cpm_pkg::NUM_CHANS; c++) begin
         back          = cpm_pkg::NUM_W'(rcp_quo_ff[c]) * span;
         fix_rem[c]    = rcp_num_ff[c] - back;
         out_rgb_in[c] = rcp_quo_ff[c] + cpm_pkg::CHAN_W'(fix_rem[c] >= span);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         rcp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (seg_en) begin
            seg_valid_ff <= frac.valid;
         end
         if (mul_en) begin
            mul_valid_ff <= seg_valid_ff;
         end
         if (rcp_en) begin
            rcp_valid_ff <= mul_valid_ff;
         end
         if (out_en) begin
            out_valid_ff <= rcp_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (seg_en) begin
         seg_k_ff  <= seg_k_in;
         seg_dt_ff <= seg_dt_in;
      end
      if (mul_en) begin
         mul_k_ff   <= seg_k_ff;
         mul_num_ff <= mul_num_in;
      end
      if (rcp_en) begin
         rcp_k_ff   <= mul_k_ff;
         rcp_num_ff <= mul_num_ff;
         rcp_quo_ff <= rcp_quo_in;
      end
      if (out_en) begin
         out_rgb_ff <= out_rgb_in;
      end
   end

   assign color.valid = out_valid_ff;
   assign color.rgb   = out_rgb_ff;

   a_recip_error_bound: assert property (@(posedge clock) disable iff (reset)
      rcp_valid_ff |->
         (fix_rem[cpm_pkg::CH_RED]   < {cpm_pkg::SEG_SPAN[rcp_k_ff], 1'b0}) &&
         (fix_rem[cpm_pkg::CH_GREEN] < {cpm_pkg::SEG_SPAN[rcp_k_ff], 1'b0}) &&
         (fix_rem[cpm_pkg::CH_BLUE]  < {cpm_pkg::SEG_SPAN[rcp_k_ff], 1'b0}))
      else $error("reciprocal quotient estimate off by more than one");

endmodule

// File: rtl/clamped_piecewise_colormap.sv
// ----------------------------------------------------------------------------
// clamped_piecewise_colormap
// Clamps a signed fixed-point sample, normalizes it against clamp_max and
// maps the fraction to 8-bit RGB through a five-segment linear colormap.
// ----------------------------------------------------------------------------
//  channel   ports                               handshake
//  request   req_valid/req_ready, req_sample     valid/ready
//  response  rsp_valid/rsp_ready, rsp_red/green/blue  valid/ready
//  config    csr_write, csr_index, csr_wdata     write strobe, no wait
//
//  One request per clock sustained while rsp_ready is held high; each
//  request reaches rsp_valid through nine register stages (clamp stage,
//  four divider stages of four quotient bits, segment select, numerator
//  multiply, reciprocal multiply, correction/output register).
//  Reset clears all valid bits and loads clamp_max = 400, clamp_min = 0.
//  Each stage holds while its successor is full and stalled; empty stages
//  keep filling, so req_ready drops only when the whole pipe is backed up.
// ----------------------------------------------------------------------------
module clamped_piecewise_colormap #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [cpm_pkg::CHAN_W-1:0]         rsp_red,
   output logic [cpm_pkg::CHAN_W-1:0]         rsp_green,
   output logic [cpm_pkg::CHAN_W-1:0]         rsp_blue,
   input  logic                               csr_write,
   input  logic [cpm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cpm_pkg::CLAMP_W-1:0]        csr_wdata
);

   localparam int EXT_W = (SAMPLE_WIDTH > cpm_pkg::CLAMP_W + 1) ? SAMPLE_WIDTH
                                                                : cpm_pkg::CLAMP_W + 1;

   logic [cpm_pkg::CLAMP_W-1:0] clamp_max_ff;
   logic [cpm_pkg::CLAMP_W-1:0] clamp_min_ff;

   logic signed [EXT_W-1:0] sample_ext, max_ext, min_ext, upper;
   cpm_pkg::div_stage_type  clamp_ff, clamp_in;
   logic                    clamp_en;
   logic                    div_ready;
   cpm_pkg::frac_type       frac;
   logic                    frac_ready;
   cpm_pkg::color_type      color;

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_max_ff <= cpm_pkg::CLAMP_MAX_RESET;
         clamp_min_ff <= cpm_pkg::CLAMP_MIN_RESET;
      end else if (csr_write) begin
         if (csr_index == cpm_pkg::CSR_CLAMP_MAX) begin
            clamp_max_ff <= csr_wdata;
         end else if (csr_index == cpm_pkg::CSR_CLAMP_MIN) begin
            clamp_min_ff <= csr_wdata;
         end
      end
   end

   // Limit to max first, then raise to min; result always fits 15 bits
   always_comb begin
      sample_ext     = EXT_W'(req_sample);
      max_ext        = EXT_W'({1'b0, clamp_max_ff});
      min_ext        = EXT_W'({1'b0, clamp_min_ff});
      upper          = (sample_ext > max_ext) ? max_ext : sample_ext;
      clamp_in.valid = req_valid;
      clamp_in.rem   = (upper < min_ext) ? clamp_min_ff : upper[cpm_pkg::CLAMP_W-1:0];
      clamp_in.sat   = clamp_in.rem >= clamp_max_ff;
      clamp_in.zero  = clamp_max_ff == '0;
      clamp_in.quo   = '0;
   end

   assign clamp_en  = !clamp_ff.valid || div_ready;
   assign req_ready = clamp_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff.valid <= 1'b0;
      end else if (clamp_en) begin
         clamp_ff <= clamp_in;
      end
   end

   cpm_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (clamp_ff),
      .start_ready (div_ready),
      .divisor     (clamp_max_ff),
      .frac        (frac),
      .frac_ready  (frac_ready)
   );

   cpm_lerp u_lerp (
      .clock       (clock),
      .reset       (reset),
      .frac        (frac),
      .frac_ready  (frac_ready),
      .color       (color),
      .color_ready (rsp_ready)
   );

   assign rsp_valid = color.valid;
   assign rsp_red   = color.rgb[cpm_pkg::CH_RED];
   assign rsp_green = color.rgb[cpm_pkg::CH_GREEN];
   assign rsp_blue  = color.rgb[cpm_pkg::CH_BLUE];

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_accept_loads_clamp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> clamp_ff.valid)
      else $error("accepted request did not enter clamp stage");

   a_clamp_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      clamp_ff.valid && !div_ready |=> clamp_ff.valid && $stable(clamp_ff.rem))
      else $error("clamp stage lost or changed a stalled request");

endmodule
